// ===== src/b64lwe_pkg.sv =====
// Shared types, constants and the sextet-to-character function of the line-wrapped base64 encoder.
`default_nettype none

package b64lwe_pkg;

	localparam logic [7:0] LINE_FEED   = 8'h0A;
	localparam logic [7:0] PAD_CHAR    = 8'h3D;
	localparam logic [7:0] WRAP_RESET  = 8'd72;
	localparam logic [2:0] IDX_FIRST   = 3'd0;
	localparam logic [2:0] IDX_NO_LF   = 3'd3;
	localparam logic [2:0] IDX_LF      = 3'd4;
	localparam logic [1:0] PAD_NONE    = 2'd0;
	localparam logic [1:0] PAD_ONE     = 2'd1;
	localparam logic [1:0] PAD_TWO     = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} byte_word_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_char;
	} char_word_t;

	// One group of up to three bytes, ready to be turned into characters.
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] pad_cnt;
		logic       lf;
		logic       last;
	} group_cmd_t;

	typedef struct packed {
		logic       full;
		logic       head_valid;
	} queue_status_t;

	function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
		logic [7:0] r;
		r = 8'h00;
		if (v < 6'd26)
			r = 8'h41 + {2'b00, v};
		else if (v < 6'd52)
			r = 8'h61 + {2'b00, v - 6'd26};
		else if (v < 6'd62)
			r = 8'h30 + {2'b00, v - 6'd52};
		else if (v == 6'd62)
			r = 8'h2B;
		else
			r = 8'h2F;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/b64lwe_front.sv =====
// Front end: takes bytes, gathers groups of three and tracks the line position.
`default_nettype none

module b64lwe_front
	import b64lwe_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wrap_length_we,
	input  wire logic [7:0]    wrap_length_wdata,
	input  wire logic          byte_valid,
	output logic               byte_ready,
	input  wire byte_word_t    byte_word,
	input  wire queue_status_t q_status,
	output logic               push,
	output group_cmd_t         push_cmd
);

	logic [7:0] wrap_len_q;
	logic [7:0] line_cnt_q;
	logic [1:0] pend_cnt_q;
	logic [7:0] pend0_q;
	logic [7:0] pend1_q;
	logic       accept;
	logic [8:0] lc_plus;
	logic       wrap_hit;
	logic       fin;

	assign byte_ready = !q_status.full;
	assign accept     = byte_valid && byte_ready;
	assign fin        = byte_word.final_byte;
	assign lc_plus    = {1'b0, line_cnt_q} + 9'd4;
	assign wrap_hit   = lc_plus >= {1'b0, wrap_len_q};
	assign push       = accept && ((pend_cnt_q == 2'd2) || fin);

	always_comb begin
		push_cmd.b0      = pend0_q;
		push_cmd.b1      = 8'h00;
		push_cmd.b2      = 8'h00;
		push_cmd.pad_cnt = PAD_NONE;
		push_cmd.last    = fin;
		push_cmd.lf      = 1'b1;
		case (pend_cnt_q)
			2'd0: begin
				push_cmd.b0      = byte_word.data_byte;
				push_cmd.pad_cnt = PAD_TWO;
			end
			2'd1: begin
				push_cmd.b1      = byte_word.data_byte;
				push_cmd.pad_cnt = PAD_ONE;
			end
			default: begin
				push_cmd.b1 = pend1_q;
				push_cmd.b2 = byte_word.data_byte;
				// A full group closes its line on a wrap or at the end of the message.
				push_cmd.lf = wrap_hit || fin;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_len_q <= WRAP_RESET;
		end else if (wrap_length_we) begin
			wrap_len_q <= wrap_length_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_cnt_q <= 8'd0;
			pend_cnt_q <= 2'd0;
		end else if (accept) begin
			if (fin) begin
				line_cnt_q <= 8'd0;
				pend_cnt_q <= 2'd0;
			end else if (pend_cnt_q == 2'd2) begin
				line_cnt_q <= wrap_hit ? 8'd0 : lc_plus[7:0];
				pend_cnt_q <= 2'd0;
			end else begin
				pend_cnt_q <= pend_cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !fin && pend_cnt_q == 2'd0)
			pend0_q <= byte_word.data_byte;
		if (accept && !fin && pend_cnt_q == 2'd1)
			pend1_q <= byte_word.data_byte;
	end

endmodule

`default_nettype wire

// ===== src/b64lwe_fifo.sv =====
// Two-entry queue of byte groups between the front end and the character stage.
`default_nettype none

module b64lwe_fifo
	import b64lwe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire group_cmd_t push_cmd,
	input  wire logic       pop,
	output queue_status_t   status,
	output group_cmd_t      head_cmd
);

	group_cmd_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign status.full       = cnt_q == 2'd2;
	assign status.head_valid = cnt_q != 2'd0;
	assign head_cmd          = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

// ===== src/b64lwe_back.sv =====
// Back end: turns one queued group into characters, one word per cycle while the receiver is ready.
`default_nettype none

module b64lwe_back
	import b64lwe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       head_valid,
	input  wire group_cmd_t head_cmd,
	output logic            pop,
	output logic            char_valid,
	input  wire logic       char_ready,
	output char_word_t      char_word
);

	logic [2:0] idx_q;
	logic [2:0] last_idx;
	logic       at_end;
	logic       advance;
	logic [5:0] sextet;
	logic [7:0] next_char;
	char_word_t word_q;
	logic       valid_q;

	assign last_idx   = head_cmd.lf ? IDX_LF : IDX_NO_LF;
	assign at_end     = idx_q == last_idx;
	assign advance    = head_valid && (!valid_q || char_ready);
	assign pop        = advance && at_end;
	assign char_valid = valid_q;
	assign char_word  = word_q;

	always_comb begin
		case (idx_q)
			3'd0:    sextet = head_cmd.b0[7:2];
			3'd1:    sextet = {head_cmd.b0[1:0], head_cmd.b1[7:4]};
			3'd2:    sextet = {head_cmd.b1[3:0], head_cmd.b2[7:6]};
			default: sextet = head_cmd.b2[5:0];
		endcase
		if (idx_q == IDX_LF)
			next_char = LINE_FEED;
		else if ((idx_q == 3'd3 && head_cmd.pad_cnt != PAD_NONE) ||
			(idx_q == 3'd2 && head_cmd.pad_cnt == PAD_TWO))
			next_char = PAD_CHAR;
		else
			next_char = sextet_to_char(sextet);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= IDX_FIRST;
			valid_q <= 1'b0;
		end else if (advance) begin
			idx_q   <= at_end ? IDX_FIRST : idx_q + 3'd1;
			valid_q <= 1'b1;
		end else if (char_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_q.out_char  <= next_char;
			word_q.last_char <= head_cmd.last && at_end;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_LF)
		else $error("character index out of range");

	a_idx_needs_group: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != IDX_FIRST |-> head_valid)
		else $error("group left the queue before all its characters were sent");

	a_stall_holds_idx: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !char_ready |=> $stable(idx_q))
		else $error("character index moved while the output word was stalled");

	a_last_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && word_q.last_char |-> word_q.out_char == LINE_FEED)
		else $error("message ended on a character other than a line feed");

endmodule

`default_nettype wire

// ===== src/base64_line_wrapped_encoder.sv =====
// A byte that completes or ends a group is pushed into the queue as it is accepted; the back end
// then registers the group's characters one at a time into the output word.
// Throughput: one byte per cycle while the two-group queue is not full; the character stage
// sends one word per cycle while the receiver is ready; three bytes give 4 characters, 5 with a line feed.
// Reset clears the line count, held byte count, queue and output valid; wrap length returns to 72.
`default_nettype none

module base64_line_wrapped_encoder
	import b64lwe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wrap_length_we,
	input  wire logic [7:0] wrap_length_wdata,
	input  wire logic       byte_valid,
	output logic            byte_ready,
	input  wire byte_word_t byte_word,
	output logic            char_valid,
	input  wire logic       char_ready,
	output char_word_t      char_word
);

	queue_status_t q_status;
	logic          push;
	group_cmd_t    push_cmd;
	logic          pop;
	group_cmd_t    head_cmd;

	b64lwe_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.wrap_length_we    (wrap_length_we),
		.wrap_length_wdata (wrap_length_wdata),
		.byte_valid        (byte_valid),
		.byte_ready        (byte_ready),
		.byte_word         (byte_word),
		.q_status          (q_status),
		.push              (push),
		.push_cmd          (push_cmd)
	);

	b64lwe_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.status   (q_status),
		.head_cmd (head_cmd)
	);

	b64lwe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_status.head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_word  (char_word)
	);

endmodule

`default_nettype wire

// ===== dv/base64_line_wrapped_encoder_tb.sv =====
// Self-checking testbench for the line-wrapped base64 encoder, with its own prediction model.
`timescale 1ns / 1ps

module base64_line_wrapped_encoder_tb;
	import b64lwe_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int RANDOM_BYTES = 24;
	localparam logic [8*64-1:0] B64_TABLE =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic       clk;
	logic       arst_n;
	logic       wrap_length_we;
	logic [7:0] wrap_length_wdata;
	logic       byte_valid;
	logic       byte_ready;
	byte_word_t byte_word;
	logic       char_valid;
	logic       char_ready;
	char_word_t char_word;

	// Predicted encoder state.
	logic [7:0] wrap_len;
	logic [7:0] held_bytes [2];
	logic [1:0] held_cnt;
	int         line_cnt;
	int         pushed_now;
	char_word_t expected_chars [$];

	int  error_count;
	int  bytes_sent;
	int  messages_sent;
	int  chars_checked;
	int  wraps_written;
	int  send_burst_left;
	bit  hold_off_request;

	base64_line_wrapped_encoder u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.wrap_length_we    (wrap_length_we),
		.wrap_length_wdata (wrap_length_wdata),
		.byte_valid        (byte_valid),
		.byte_ready        (byte_ready),
		.byte_word         (byte_word),
		.char_valid        (char_valid),
		.char_ready        (char_ready),
		.char_word         (char_word)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		return B64_TABLE[8 * (63 - v) +: 8];
	endfunction

	function automatic void push_char(input logic [7:0] c);
		char_word_t w;
		w.out_char = c;
		w.last_char = 1'b0;
		expected_chars.push_back(w);
		pushed_now++;
	endfunction

	// Works out the characters one accepted byte produces and updates the predicted state.
	task automatic encode_byte_expect(input logic [7:0] b, input logic fin);
		int lc;
		logic [7:0] b0;
		logic [7:0] b1;
		lc = line_cnt;
		pushed_now = 0;
		if (held_cnt >= 2) begin
			b0 = held_bytes[0];
			b1 = held_bytes[1];
			push_char(b64_char(b0[7:2]));
			push_char(b64_char({b0[1:0], b1[7:4]}));
			push_char(b64_char({b1[3:0], b[7:6]}));
			push_char(b64_char(b[5:0]));
			held_cnt = 2'd0;
			lc += 4;
			if (lc >= int'(wrap_len)) begin
				push_char(LINE_FEED);
				lc = 0;
			end
		end else begin
			held_bytes[held_cnt[0]] = b;
			held_cnt = held_cnt + 2'd1;
		end
		if (fin) begin
			if (held_cnt != 2'd0) begin
				b0 = held_bytes[0];
				push_char(b64_char(b0[7:2]));
				if (held_cnt == 2'd1) begin
					push_char(b64_char({b0[1:0], 4'b0000}));
					push_char(PAD_CHAR);
				end else begin
					b1 = held_bytes[1];
					push_char(b64_char({b0[1:0], b1[7:4]}));
					push_char(b64_char({b1[3:0], 2'b00}));
				end
				push_char(PAD_CHAR);
				lc += 4;
			end
			if (lc != 0)
				push_char(LINE_FEED);
			if (pushed_now > 0)
				expected_chars[expected_chars.size() - 1].last_char = 1'b1;
			held_bytes[0] = 8'h00;
			held_bytes[1] = 8'h00;
			held_cnt = 2'd0;
			lc = 0;
		end
		line_cnt = lc;
	endtask

	function automatic int pick_send_gap();
		int r;
		if (send_burst_left > 0) begin
			send_burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5)
			send_burst_left = $urandom_range(20, 60);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_byte(input logic [7:0] d, input logic fin);
		int gap;
		gap = pick_send_gap();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_word.data_byte <= d;
		byte_word.final_byte <= fin;
		do
			@(posedge clk);
		while (!byte_ready);
		encode_byte_expect(d, fin);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), i == len - 1);
		messages_sent++;
	endtask

	task automatic send_fixed(input logic [7:0] d0, input logic [7:0] d1, input logic [7:0] d2,
			input logic [7:0] d3, input int len);
		logic [7:0] msg [4];
		msg = '{d0, d1, d2, d3};
		for (int i = 0; i < len; i++)
			send_byte(msg[i], i == len - 1);
		messages_sent++;
	endtask

	// The block must be idle: every predicted word seen, then a few spare cycles.
	task automatic set_wrap_length(input logic [7:0] len);
		byte_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		wrap_length_we <= 1'b1;
		wrap_length_wdata <= len;
		@(negedge clk);
		wrap_length_we <= 1'b0;
		wrap_len = len;
		wraps_written++;
	endtask

	// Reset length of 72: one and two leftover bytes, a full group, extreme byte values.
	task automatic test_default_wrap();
		send_fixed(8'h00, 8'h00, 8'h00, 8'h00, 1);
		send_fixed(8'hFF, 8'hFF, 8'h00, 8'h00, 2);
		send_fixed(8'h4D, 8'h61, 8'h6E, 8'h00, 3);
		send_fixed(8'h00, 8'hFF, 8'h80, 8'h7F, 4);
	endtask

	// A final byte that completes a group right at the wrap point gets a single line feed.
	task automatic test_wrap_at_group_end();
		set_wrap_length(8'd4);
		send_fixed(8'hFF, 8'h00, 8'hFF, 8'h00, 3);
		send_fixed(8'h01, 8'h02, 8'h03, 8'hFE, 4);
		send_fixed(8'hAA, 8'h55, 8'h00, 8'h00, 2);
	endtask

	// A length past 252 wraps only after the group that passes it; the receiver holds off
	// long enough for the input side to stall.
	task automatic test_long_lines();
		set_wrap_length(8'd255);
		hold_off_request = 1'b1;
		send_message(192);
	endtask

	task automatic test_random_messages();
		int random_bytes;
		int len;
		logic [7:0] wl;
		random_bytes = 0;
		while (random_bytes < RANDOM_BYTES) begin
			case ($urandom_range(0, 9))
				0: wl = 8'd0;
				1: wl = 8'd3;
				2: wl = 8'd253;
				3: wl = 8'd255;
				4: wl = 8'd4;
				5: wl = 8'd252;
				default: wl = 8'($urandom_range(4, 40));
			endcase
			set_wrap_length(wl);
			repeat ($urandom_range(1, 4)) begin
				if (random_bytes < RANDOM_BYTES) begin
					if ($urandom_range(0, 9) < 8)
						len = $urandom_range(1, 12);
					else
						len = $urandom_range(13, 50);
					if (len > RANDOM_BYTES - random_bytes)
						len = RANDOM_BYTES - random_bytes;
					send_message(len);
					random_bytes += len;
				end
			end
		end
	endtask

	// Receiver: mostly ready, short and occasional long stalls, some stretches with no stalls.
	initial begin
		int r;
		int no_stall_left;
		char_ready = 1'b0;
		no_stall_left = 0;
		@(negedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				char_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
			end else if (no_stall_left > 0 || r < 60) begin
				if (no_stall_left > 0)
					no_stall_left--;
				char_ready <= 1'b1;
				@(negedge clk);
			end else if (r < 65) begin
				no_stall_left = $urandom_range(30, 80);
				char_ready <= 1'b1;
				@(negedge clk);
			end else if (r < 96) begin
				char_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end else begin
				char_ready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_words
		char_word_t want;
		if (arst_n && char_valid && char_ready) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected word: out_char=%h last_char=%b",
					char_word.out_char, char_word.last_char);
				error_count++;
			end else begin
				want = expected_chars.pop_front();
				chars_checked++;
				if (char_word.out_char !== want.out_char) begin
					$error("out_char: expected %h, actual %h", want.out_char, char_word.out_char);
					error_count++;
				end
				if (char_word.last_char !== want.last_char) begin
					$error("last_char: expected %b, actual %b",
						want.last_char, char_word.last_char);
					error_count++;
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		wrap_length_we = 1'b0;
		wrap_length_wdata = 8'h00;
		byte_valid = 1'b0;
		byte_word = '0;
		wrap_len = WRAP_RESET;
		held_bytes[0] = 8'h00;
		held_bytes[1] = 8'h00;
		held_cnt = 2'd0;
		line_cnt = 0;
		error_count = 0;
		bytes_sent = 0;
		messages_sent = 0;
		chars_checked = 0;
		wraps_written = 0;
		send_burst_left = 0;
		hold_off_request = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_wrap();
		test_wrap_at_group_end();
		test_long_lines();
		test_random_messages();

		byte_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Encoded %0d bytes in %0d messages; %0d characters checked.",
			bytes_sent, messages_sent, chars_checked);
		$display("Line length set %0d times; a long receiver hold stalled the input.",
			wraps_written);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== base64_line_wrapped_encoder.f =====
src/b64lwe_pkg.sv
src/b64lwe_front.sv
src/b64lwe_fifo.sv
src/b64lwe_back.sv
src/base64_line_wrapped_encoder.sv
dv/base64_line_wrapped_encoder_tb.sv
